/* hdl/fcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_FIRST       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_SECOND      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_FIRST       = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SECOND      = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM_CHECK_ENABLE = 8'd4;

  localparam logic [7:0] HEAD_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HEAD_SECOND_RESET = 8'hAA;
  localparam logic [7:0] TAIL_FIRST_RESET  = 8'h0D;
  localparam logic [7:0] TAIL_SECOND_RESET = 8'h0A;

  // command codes
  localparam logic [7:0] CMD_DRIVE   = 8'h01;
  localparam logic [7:0] CMD_CONTROL = 8'h02;
  localparam logic [7:0] CMD_HORN    = 8'hF1;
  localparam logic [7:0] CMD_LIGHT   = 8'hF2;

  // function bits
  localparam logic [7:0] BIT_STOP  = 8'h01;
  localparam logic [7:0] BIT_LIGHT = 8'h02;
  localparam logic [7:0] BIT_HORN  = 8'h04;

  // data bytes that the decoder reads
  localparam int unsigned DECODE_BYTES = 4;
  localparam int unsigned DECODE_IDX_W = $clog2(DECODE_BYTES);

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
    logic       sum_check_enable;
  } fcr_cfg_t;

  typedef struct packed {
    logic              link_online;
    logic              run_allowed;
    logic [7:0]        function_bits;
    logic [7:0]        horn_request;
    logic [7:0]        light_request;
    logic signed [7:0] speed_command;
    logic signed [7:0] steer_command;
    logic [7:0]        mode_command;
    logic [31:0]       last_frame_time;
    logic [7:0]        last_command;
  } fcr_status_t;

  typedef struct packed {
    logic        frame_accepted;
    fcr_status_t status;
  } fcr_result_t;

endpackage

`default_nettype wire

/* hdl/fcr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface fcr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface fcr_out_if;
  logic              valid;
  logic              ready;
  logic              frame_accepted;
  logic              link_online;
  logic              run_allowed;
  logic [7:0]        function_bits;
  logic [7:0]        horn_request;
  logic [7:0]        light_request;
  logic signed [7:0] speed_command;
  logic signed [7:0] steer_command;
  logic [7:0]        mode_command;
  logic [31:0]       last_frame_time;
  logic [7:0]        last_command;

  modport source (
    output valid, output frame_accepted, output link_online, output run_allowed,
    output function_bits, output horn_request, output light_request,
    output speed_command, output steer_command, output mode_command,
    output last_frame_time, output last_command, input ready
  );
  modport sink (
    input valid, input frame_accepted, input link_online, input run_allowed,
    input function_bits, input horn_request, input light_request,
    input speed_command, input steer_command, input mode_command,
    input last_frame_time, input last_command, output ready
  );
endinterface

interface fcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/fcr_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcr_cfg_regs
  import fcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fcr_cfg_if.sink   cfg_ch,
  output fcr_cfg_t  cfg
);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_first       <= HEAD_FIRST_RESET;
      cfg.head_second      <= HEAD_SECOND_RESET;
      cfg.tail_first       <= TAIL_FIRST_RESET;
      cfg.tail_second      <= TAIL_SECOND_RESET;
      cfg.sum_check_enable <= 1'b0;
    end else if (cfg_ch.valid) begin
      // drop writes to unknown indexes
      unique case (cfg_ch.index)
        REG_HEAD_FIRST:       cfg.head_first       <= cfg_ch.data;
        REG_HEAD_SECOND:      cfg.head_second      <= cfg_ch.data;
        REG_TAIL_FIRST:       cfg.tail_first       <= cfg_ch.data;
        REG_TAIL_SECOND:      cfg.tail_second      <= cfg_ch.data;
        REG_SUM_CHECK_ENABLE: cfg.sum_check_enable <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/fcr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcr_parser
  import fcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] now_ms,
  input  wire fcr_cfg_t    cfg,
  output fcr_result_t      result
);

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_TAIL1,
    PH_TAIL2
  } phase_t;

  localparam fcr_status_t STATUS_RESET = '{run_allowed: 1'b1, default: '0};

  phase_t      phase, phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  data_count, data_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  kept_data [DECODE_BYTES];
  logic        kept_we;
  fcr_status_t status, status_next;
  logic        accepted;
  logic [7:0]  d0;

  assign d0 = kept_data[0];

  always_comb begin
    phase_next         = phase;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    data_count_next    = data_count;
    running_sum_next   = running_sum;
    status_next        = status;
    kept_we            = 1'b0;
    accepted           = 1'b0;

    unique case (phase)
      PH_HEAD1: begin
        if (rx_byte == cfg.head_first) begin
          phase_next       = PH_HEAD2;
          running_sum_next = '0;
        end
      end
      PH_HEAD2: begin
        phase_next = (rx_byte == cfg.head_second) ? PH_CMD : PH_HEAD1;
      end
      PH_CMD: begin
        frame_command_next = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next = rx_byte;
        running_sum_next  = running_sum + rx_byte;
        data_count_next   = '0;
        phase_next        = (rx_byte != 8'd0) ? PH_DATA : PH_SUM;
      end
      PH_DATA: begin
        kept_we          = (data_count < 8'(DECODE_BYTES));
        data_count_next  = data_count + 8'd1;
        running_sum_next = running_sum + rx_byte;
        if (data_count_next >= frame_length) phase_next = PH_SUM;
      end
      PH_SUM: begin
        if (cfg.sum_check_enable && (rx_byte != running_sum)) phase_next = PH_HEAD1;
        else phase_next = PH_TAIL1;
      end
      PH_TAIL1: begin
        phase_next = (rx_byte == cfg.tail_first) ? PH_TAIL2 : PH_HEAD1;
      end
      PH_TAIL2: begin
        phase_next = PH_HEAD1;
        if (rx_byte == cfg.tail_second) begin
          accepted                    = 1'b1;
          status_next.link_online     = 1'b1;
          status_next.last_frame_time = now_ms;
          status_next.last_command    = frame_command;
          unique case (frame_command)
            CMD_DRIVE: begin
              if (frame_length != 8'd0) begin
                if (d0 == 8'd0) begin
                  status_next.run_allowed   = 1'b0;
                  status_next.function_bits = status.function_bits | BIT_STOP;
                end else begin
                  status_next.run_allowed   = 1'b1;
                  status_next.function_bits = status.function_bits & ~BIT_STOP;
                end
              end
            end
            CMD_HORN: begin
              if (frame_length != 8'd0) begin
                status_next.horn_request = d0;
                if (d0 != 8'd0) status_next.function_bits = status.function_bits | BIT_HORN;
                else status_next.function_bits = status.function_bits & ~BIT_HORN;
              end
            end
            CMD_LIGHT: begin
              if (frame_length != 8'd0) begin
                status_next.light_request = d0;
                if (d0 != 8'd0) status_next.function_bits = status.function_bits | BIT_LIGHT;
                else status_next.function_bits = status.function_bits & ~BIT_LIGHT;
              end
            end
            CMD_CONTROL: begin
              if (frame_length >= 8'(DECODE_BYTES)) begin
                status_next.speed_command = kept_data[0];
                status_next.steer_command = kept_data[1];
                status_next.function_bits = kept_data[2];
                status_next.mode_command  = kept_data[3];
                status_next.run_allowed   = ~kept_data[2][0];
              end
            end
            default: ;
          endcase
        end
      end
      default: phase_next = PH_HEAD1;
    endcase
  end

  assign result.frame_accepted = accepted;
  assign result.status         = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD1;
      frame_command <= '0;
      frame_length  <= '0;
      data_count    <= '0;
      running_sum   <= '0;
      status        <= STATUS_RESET;
    end else if (step) begin
      phase         <= phase_next;
      frame_command <= frame_command_next;
      frame_length  <= frame_length_next;
      data_count    <= data_count_next;
      running_sum   <= running_sum_next;
      status        <= status_next;
    end
  end

  // only the first data bytes of a frame are kept
  always_ff @(posedge clk) begin
    if (step && kept_we) kept_data[data_count[DECODE_IDX_W-1:0]] <= rx_byte;
  end

endmodule

`default_nettype wire

/* hdl/fcr_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcr_out_stage
  import fcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire fcr_result_t result,
  output logic             space,
  fcr_out_if.source        out_ch
);

  logic        valid;
  fcr_result_t held;

  // take a new result when empty or when the held one leaves this cycle
  assign space = ~valid | out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= result;
  end

  assign out_ch.valid           = valid;
  assign out_ch.frame_accepted  = held.frame_accepted;
  assign out_ch.link_online     = held.status.link_online;
  assign out_ch.run_allowed     = held.status.run_allowed;
  assign out_ch.function_bits   = held.status.function_bits;
  assign out_ch.horn_request    = held.status.horn_request;
  assign out_ch.light_request   = held.status.light_request;
  assign out_ch.speed_command   = held.status.speed_command;
  assign out_ch.steer_command   = held.status.steer_command;
  assign out_ch.mode_command    = held.status.mode_command;
  assign out_ch.last_frame_time = held.status.last_frame_time;
  assign out_ch.last_command    = held.status.last_command;

endmodule

`default_nettype wire

/* hdl/framed_command_receiver_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// in_ch     in   rx_byte[7:0], now_ms[31:0]
// out_ch    out  frame_accepted, link state and last command fields
// cfg_ch    in   index[7:0], data[7:0]
//
// One byte per cycle unless out_ch stalls: the parser updates its state and
// forms the result in the cycle the byte is accepted; the result register
// shows it in the next cycle. A result is produced for every byte.
// Reset (rst, synchronous) returns the parser to header search and restores
// register defaults. When out_ch stalls, one result is held and in_ch.ready
// drops until it is taken. cfg_ch is always ready.
module framed_command_receiver_unit
  import fcr_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  fcr_in_if.sink    in_ch,
  fcr_out_if.source out_ch,
  fcr_cfg_if.sink   cfg_ch
);

  fcr_cfg_t    cfg;
  fcr_result_t result;
  logic        space;
  logic        step;

  assign in_ch.ready = space;
  assign step        = in_ch.valid & space;

  fcr_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fcr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_ch.rx_byte),
    .now_ms  (in_ch.now_ms),
    .cfg     (cfg),
    .result  (result)
  );

  fcr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .result (result),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* tb/sv/framed_command_receiver_unit_tb.sv */
`timescale 1ns / 1ps

module framed_command_receiver_unit_tb;
  import fcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_REPORTS = 40;
  // indexes past the last register; writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED     = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = 8'hFF;

  typedef enum logic [2:0] {
    SEEK_HEAD1, SEEK_HEAD2, TAKE_CMD, TAKE_LEN,
    TAKE_DATA, TAKE_SUM, SEEK_TAIL1, SEEK_TAIL2
  } parse_e;

  // one byte on the wire, with values typed in for rows that can be read at a glance
  typedef struct packed {
    logic [7:0]  rx;
    logic [31:0] ms;
    logic        pinned;
    logic        accepted;
    logic        online;
    logic [7:0]  command;
  } row_t;

  logic clk;
  logic rst = 1'b1;

  fcr_in_if  in_ch ();
  fcr_out_if out_ch ();
  fcr_cfg_if cfg_ch ();

  framed_command_receiver_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // parser copy
  fcr_cfg_t    rules;
  parse_e      parse_at;
  logic [7:0]  frame_cmd;
  logic [7:0]  frame_len;
  logic [7:0]  data_seen;
  logic [7:0]  frame_sum;
  logic [7:0]  kept [DECODE_BYTES];
  fcr_status_t held;

  fcr_result_t status_due [$];
  row_t        row_notes [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned frames_seen = 0;
  int unsigned writes = 0;
  logic [31:0] clock_ms = 32'd0;
  bit          steady = 1'b0;

  row_t script [31] = '{
    '{8'h00, 32'd0, 1'b1, 1'b0, 1'b0, 8'h00},
    '{HEAD_FIRST_RESET, 32'd1, 1'b0, 1'b0, 1'b0, 8'h00},
    // second header wrong: this byte must not restart the frame
    '{HEAD_FIRST_RESET, 32'd2, 1'b0, 1'b0, 1'b0, 8'h00},
    '{HEAD_SECOND_RESET, 32'd3, 1'b1, 1'b0, 1'b0, 8'h00},
    // drive frame with zero length
    '{HEAD_FIRST_RESET, 32'd4, 1'b0, 1'b0, 1'b0, 8'h00},
    '{HEAD_SECOND_RESET, 32'd5, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DRIVE, 32'd6, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 32'd7, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h5A, 32'd8, 1'b0, 1'b0, 1'b0, 8'h00},
    '{TAIL_FIRST_RESET, 32'd9, 1'b0, 1'b0, 1'b0, 8'h00},
    '{TAIL_SECOND_RESET, 32'd100, 1'b1, 1'b1, 1'b1, CMD_DRIVE},
    // control frame longer than the kept store, extreme setpoints
    '{HEAD_FIRST_RESET, 32'd101, 1'b0, 1'b0, 1'b0, 8'h00},
    '{HEAD_SECOND_RESET, 32'd102, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_CONTROL, 32'd103, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h05, 32'd104, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h80, 32'd105, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 32'd106, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h03, 32'd107, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 32'd108, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hEE, 32'd109, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 32'd110, 1'b0, 1'b0, 1'b0, 8'h00},
    '{TAIL_FIRST_RESET, 32'd111, 1'b0, 1'b0, 1'b0, 8'h00},
    '{TAIL_SECOND_RESET, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, CMD_CONTROL},
    // horn frame with a bad second tail
    '{HEAD_FIRST_RESET, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{HEAD_SECOND_RESET, 32'd1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_HORN, 32'd2, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h01, 32'd3, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 32'd4, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 32'd5, 1'b0, 1'b0, 1'b0, 8'h00},
    '{TAIL_FIRST_RESET, 32'd6, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h0B, 32'd7, 1'b1, 1'b0, 1'b1, CMD_CONTROL}
  };

  function automatic fcr_result_t parse_byte(logic [7:0] b, logic [31:0] now);
    fcr_result_t r;
    r.frame_accepted = 1'b0;
    case (parse_at)
      SEEK_HEAD1: begin
        if (b == rules.head_first) begin
          parse_at = SEEK_HEAD2;
          frame_sum = 8'd0;
        end
      end
      SEEK_HEAD2: begin
        if (b == rules.head_second) parse_at = TAKE_CMD;
        else parse_at = SEEK_HEAD1;
      end
      TAKE_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        parse_at = TAKE_LEN;
      end
      TAKE_LEN: begin
        frame_len = b;
        frame_sum = frame_sum + b;
        data_seen = 8'd0;
        if (b != 8'd0) parse_at = TAKE_DATA;
        else parse_at = TAKE_SUM;
      end
      TAKE_DATA: begin
        if (data_seen < DECODE_BYTES) kept[data_seen] = b;
        data_seen = data_seen + 8'd1;
        frame_sum = frame_sum + b;
        if (data_seen >= frame_len) parse_at = TAKE_SUM;
      end
      TAKE_SUM: begin
        if (rules.sum_check_enable && b != frame_sum) parse_at = SEEK_HEAD1;
        else parse_at = SEEK_TAIL1;
      end
      SEEK_TAIL1: begin
        if (b == rules.tail_first) parse_at = SEEK_TAIL2;
        else parse_at = SEEK_HEAD1;
      end
      default: begin
        if (b == rules.tail_second) begin
          r.frame_accepted = 1'b1;
          held.link_online = 1'b1;
          held.last_frame_time = now;
          held.last_command = frame_cmd;
          case (frame_cmd)
            CMD_DRIVE: begin
              if (frame_len >= 8'd1) begin
                held.run_allowed = (kept[0] != 8'd0);
                if (kept[0] == 8'd0) held.function_bits = held.function_bits | BIT_STOP;
                else held.function_bits = held.function_bits & ~BIT_STOP;
              end
            end
            CMD_HORN: begin
              if (frame_len >= 8'd1) begin
                held.horn_request = kept[0];
                if (kept[0] != 8'd0) held.function_bits = held.function_bits | BIT_HORN;
                else held.function_bits = held.function_bits & ~BIT_HORN;
              end
            end
            CMD_LIGHT: begin
              if (frame_len >= 8'd1) begin
                held.light_request = kept[0];
                if (kept[0] != 8'd0) held.function_bits = held.function_bits | BIT_LIGHT;
                else held.function_bits = held.function_bits & ~BIT_LIGHT;
              end
            end
            CMD_CONTROL: begin
              if (frame_len >= 8'd4) begin
                held.speed_command = kept[0];
                held.steer_command = kept[1];
                held.function_bits = kept[2];
                held.mode_command = kept[3];
                held.run_allowed = ((kept[2] & BIT_STOP) == 8'd0);
              end
            end
            default: ;
          endcase
        end
        parse_at = SEEK_HEAD1;
      end
    endcase
    r.status = held;
    return r;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : observe
    fcr_result_t want;
    row_t        note;
    if (!rst && in_ch.valid && in_ch.ready) begin
      note = row_notes.pop_front();
      want = parse_byte(in_ch.rx_byte, in_ch.now_ms);
      if (note.pinned && {want.frame_accepted, want.status.link_online,
                          want.status.last_command} !== {note.accepted, note.online,
                                                         note.command})
        report($sformatf("directed byte 0x%02h: accepted %0b online %0b command 0x%02h",
                         note.rx, want.frame_accepted, want.status.link_online,
                         want.status.last_command));
      status_due.push_back(want);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        want = status_due.pop_front();
        if (out_ch.frame_accepted === 1'b1) frames_seen++;
        check_field("frame_accepted", out_ch.frame_accepted, want.frame_accepted);
        check_field("link_online", out_ch.link_online, want.status.link_online);
        check_field("run_allowed", out_ch.run_allowed, want.status.run_allowed);
        check_field("function_bits", out_ch.function_bits, want.status.function_bits);
        check_field("horn_request", out_ch.horn_request, want.status.horn_request);
        check_field("light_request", out_ch.light_request, want.status.light_request);
        check_field("speed_command", out_ch.speed_command, want.status.speed_command);
        check_field("steer_command", out_ch.steer_command, want.status.steer_command);
        check_field("mode_command", out_ch.mode_command, want.status.mode_command);
        check_field("last_frame_time", out_ch.last_frame_time,
                    want.status.last_frame_time);
        check_field("last_command", out_ch.last_command, want.status.last_command);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, status_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall before each transaction, none while steady
  initial begin : take_results
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic send_byte(row_t r);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    row_notes.push_back(r);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= r.rx;
    in_ch.now_ms <= r.ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic feed_byte(logic [7:0] b);
    row_t r;
    clock_ms = clock_ms + $urandom_range(0, 40);
    r = '0;
    r.rx = b;
    r.ms = ($urandom_range(0, 7) == 0) ? $urandom : clock_ms;
    send_byte(r);
  endtask

  // hold off until every expected result is back, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0 || row_notes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_HEAD_FIRST:       rules.head_first = val;
      REG_HEAD_SECOND:      rules.head_second = val;
      REG_TAIL_FIRST:       rules.tail_first = val;
      REG_TAIL_SECOND:      rules.tail_second = val;
      REG_SUM_CHECK_ENABLE: rules.sum_check_enable = val[0];
      default: ;
    endcase
    writes++;
  endtask

  // one frame under the current markers; sometimes with a bad sum, a bad tail or cut short
  task automatic send_frame(inout int unsigned fed);
    logic [7:0]  seq [$];
    logic [7:0]  code;
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  d;
    int unsigned roll;
    int unsigned cut;
    roll = $urandom_range(0, 4);
    case (roll)
      0: code = CMD_DRIVE;
      1: code = CMD_CONTROL;
      2: code = CMD_HORN;
      3: code = CMD_LIGHT;
      default: code = 8'($urandom);
    endcase
    roll = $urandom_range(0, 99);
    if (code == CMD_CONTROL && roll < 60) len = 8'($urandom_range(4, 6));
    else if (roll < 10) len = 8'd0;
    else if (roll < 85) len = 8'($urandom_range(1, 6));
    else if (roll < 98) len = 8'($urandom_range(7, 24));
    else len = 8'($urandom_range(200, 255));
    seq = {rules.head_first, rules.head_second, code, len};
    sum = code + len;
    for (int i = 0; i < len; i++) begin
      d = (i == 0 && $urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      seq.push_back(d);
      sum = sum + d;
    end
    if ($urandom_range(0, 4) == 0) seq.push_back(sum ^ 8'($urandom_range(1, 255)));
    else seq.push_back(sum);
    roll = $urandom_range(0, 99);
    if (roll < 6) seq.push_back(rules.tail_first ^ 8'($urandom_range(1, 255)));
    else seq.push_back(rules.tail_first);
    if (roll >= 6 && roll < 12) seq.push_back(rules.tail_second ^ 8'($urandom_range(1, 255)));
    else seq.push_back(rules.tail_second);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < cut; i++) feed_byte(seq[i]);
    fed += cut;
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned fed;
    bit          paused;
    fed = 0;
    paused = 1'b0;
    while (fed < quota) begin
      if ($urandom_range(0, 29) == 0) steady = ($urandom_range(0, 2) == 0);
      // line noise between frames
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 4)) feed_byte(8'($urandom));
      send_frame(fed);
      if (!paused && fed >= quota / 2) begin
        settle();
        paused = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  initial begin : run
    logic [7:0] common_byte;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'd0;
    in_ch.now_ms = 32'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rules.head_first = HEAD_FIRST_RESET;
    rules.head_second = HEAD_SECOND_RESET;
    rules.tail_first = TAIL_FIRST_RESET;
    rules.tail_second = TAIL_SECOND_RESET;
    rules.sum_check_enable = 1'b0;
    parse_at = SEEK_HEAD1;
    frame_cmd = 8'd0;
    frame_len = 8'd0;
    data_seen = 8'd0;
    frame_sum = 8'd0;
    foreach (kept[i]) kept[i] = 8'd0;
    held = '0;
    held.run_allowed = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_byte(script[i]);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cfg_write(REG_SUM_CHECK_ENABLE, 8'd1);
        1: begin
          cfg_write(REG_HEAD_FIRST, 8'h00);
          cfg_write(REG_HEAD_SECOND, 8'hFF);
          cfg_write(REG_TAIL_FIRST, 8'hFF);
          cfg_write(REG_TAIL_SECOND, 8'h00);
          // only bit 0 enables the check
          cfg_write(REG_SUM_CHECK_ENABLE, 8'hFE);
          cfg_write(REG_UNUSED, 8'h33);
        end
        2: begin
          cfg_write(REG_HEAD_FIRST, 8'hFF);
          cfg_write(REG_HEAD_SECOND, 8'h00);
          cfg_write(REG_TAIL_FIRST, 8'h00);
          cfg_write(REG_TAIL_SECOND, 8'hFF);
          cfg_write(REG_SUM_CHECK_ENABLE, 8'hFF);
        end
        3: begin
          cfg_write(REG_HEAD_FIRST, 8'($urandom));
          cfg_write(REG_HEAD_SECOND, 8'($urandom));
          cfg_write(REG_TAIL_FIRST, 8'($urandom));
          cfg_write(REG_TAIL_SECOND, 8'($urandom));
          cfg_write(REG_SUM_CHECK_ENABLE, 8'($urandom));
          cfg_write(REG_LAST_INDEX, 8'($urandom));
        end
        4: begin
          // every marker the same byte
          common_byte = 8'($urandom);
          cfg_write(REG_HEAD_FIRST, common_byte);
          cfg_write(REG_HEAD_SECOND, common_byte);
          cfg_write(REG_TAIL_FIRST, common_byte);
          cfg_write(REG_TAIL_SECOND, common_byte);
          cfg_write(REG_SUM_CHECK_ENABLE, 8'd0);
        end
        default: begin
          cfg_write(REG_HEAD_FIRST, HEAD_FIRST_RESET);
          cfg_write(REG_HEAD_SECOND, HEAD_SECOND_RESET);
          cfg_write(REG_TAIL_FIRST, TAIL_FIRST_RESET);
          cfg_write(REG_TAIL_SECOND, TAIL_SECOND_RESET);
          cfg_write(REG_SUM_CHECK_ENABLE, 8'd1);
        end
      endcase
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
      run_random(190);
      settle();
    end

    $display("fed %0d bytes: directed script, then six marker settings; %0d frames completed",
             sent, frames_seen);
    $display("%0d register writes, sum check both ways, markers at 0x00/0xFF and random",
             writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
